// File: src/ill_pkg.sv
// Shared types and constants for the indexed linked list block.
// No dependencies; imported by ill_store and indexed_linked_list.
`default_nettype none

package ill_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LEN_W    = SLOT_W + 1;
  localparam int POS_W    = 11;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_APPEND = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_PLACE,
    S_WALK,
    S_VAL,
    S_INS_A,
    S_INS_B,
    S_DEL_HEAD,
    S_DEL_V,
    S_DEL_N,
    S_DEL_F,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              link_re;
    logic [SLOT_W-1:0] link_raddr;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic              val_re;
    logic [SLOT_W-1:0] val_raddr;
    logic              val_we;
    logic [SLOT_W-1:0] val_waddr;
    logic [DATA_W-1:0] val_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: src/ill_store.sv
// Value and link memories of the list, one write and one read port each.
// Depends on ill_pkg for widths and the request struct.
`default_nettype none

module ill_store
  import ill_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic      [SLOT_W-1:0] link_rdata,
  output logic      [DATA_W-1:0] val_rdata
);

  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [DATA_W-1:0] val_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_re) begin
      link_rdata <= link_mem[req.link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[req.val_waddr] <= req.val_wdata;
    end
    if (req.val_re) begin
      val_rdata <= val_mem[req.val_raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/indexed_linked_list.sv
// Top level of the indexed linked list: sequencer, list registers and result register.
// Depends on ill_pkg and ill_store.
//
//   channel | direction | ports                               | handshake
//   in      | input     | in_op, in_position, in_value        | in_valid / in_stall
//   out     | output    | out_status, out_read_value          | out_valid / out_stall
//
// One word is handled at a time. Reaching position p walks the link memory one
// entry per cycle. Reset (synchronous, rst_n low) empties the list; memory
// contents are not cleared. A new word is taken while a result still waits
// under out_stall, but the next result waits for the register to free up.
`default_nettype none

module indexed_linked_list
  import ill_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [OP_W-1:0]   in_op,
  input  wire logic        [POS_W-1:0]  in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic             [STAT_W-1:0] out_status,
  output logic signed      [DATA_W-1:0] out_read_value
);

  state_t state_r, state_nxt;

  // List bookkeeping.
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SLOT_W-1:0] free_head_r, free_head_nxt;
  logic [LEN_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [LEN_W-1:0]  fresh_r, fresh_nxt;

  // Current request and walk registers.
  op_t               op_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] new_r, new_nxt;
  logic [SLOT_W-1:0] victim_r, victim_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] rv_r, rv_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_rv_r;

  mem_req_t          req;
  logic [SLOT_W-1:0] link_rdata;
  logic [DATA_W-1:0] val_rdata;

  logic              accept;
  logic              out_free;
  logic              is_ins;
  logic [POS_W-1:0]  pos_eff;
  logic [POS_W-1:0]  len_ext;
  logic              range_bad;
  logic              full;
  logic [SLOT_W-1:0] eff_slot;

  ill_store u_store (
    .clk        (clk),
    .req        (req),
    .link_rdata (link_rdata),
    .val_rdata  (val_rdata)
  );

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign is_ins    = (op_r == OP_INSERT) || (op_r == OP_APPEND);
  assign len_ext   = POS_W'(len_r);
  assign pos_eff   = (op_r == OP_APPEND) ? len_ext : pos_r;
  assign range_bad = is_ins ? (pos_eff > len_ext) : (pos_eff >= len_ext);
  assign full      = (len_r == LEN_W'(CAPACITY));

  // While a link read is in flight the walk continues from its data.
  assign eff_slot = pend_r ? link_rdata : cur_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (range_bad || (is_ins && full)) begin
          state_nxt = S_RESP;
        end else begin
          case (op_r)
            OP_READ:   state_nxt = S_WALK;
            OP_DELETE: state_nxt = (pos_r == '0) ? S_DEL_HEAD : S_WALK;
            default:   state_nxt = (free_cnt_r != '0) ? S_ALLOC : S_PLACE;
          endcase
        end
      end
      S_ALLOC: state_nxt = S_PLACE;
      S_PLACE: state_nxt = (pos_r == '0) ? S_RESP : S_WALK;
      S_WALK: begin
        if (rem_r == '0) begin
          case (op_r)
            OP_READ:   state_nxt = S_VAL;
            OP_DELETE: state_nxt = S_DEL_V;
            default:   state_nxt = S_INS_A;
          endcase
        end
      end
      S_VAL:      state_nxt = S_RESP;
      S_INS_A:    state_nxt = S_INS_B;
      S_INS_B:    state_nxt = S_RESP;
      S_DEL_HEAD: state_nxt = S_DEL_F;
      S_DEL_V:    state_nxt = S_DEL_N;
      S_DEL_N:    state_nxt = S_DEL_F;
      S_DEL_F:    state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory requests and register updates.
  always_comb begin
    req           = '0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    fresh_nxt     = fresh_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    new_nxt       = new_r;
    victim_nxt    = victim_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    out_valid_nxt = (out_valid_r && out_stall) || (state_r == S_RESP);

    case (state_r)
      S_IDLE: begin
        pos_nxt = in_position;
      end
      S_CHECK: begin
        pos_nxt = pos_eff;
        rv_nxt  = '0;
        cur_nxt = head_r;
        if (range_bad) begin
          status_nxt = ST_RANGE;
        end else if (is_ins && full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          case (op_r)
            OP_READ: begin
              rem_nxt = pos_eff[SLOT_W-1:0];
            end
            OP_DELETE: begin
              rem_nxt = SLOT_W'(pos_eff - POS_W'(1));
              if (pos_eff == '0) begin
                req.link_re    = 1'b1;
                req.link_raddr = head_r;
                victim_nxt     = head_r;
              end
            end
            default: begin
              // Reuse a freed slot first, else hand out the next unused one.
              if (free_cnt_r != '0) begin
                new_nxt        = free_head_r;
                req.link_re    = 1'b1;
                req.link_raddr = free_head_r;
              end else begin
                new_nxt   = fresh_r[SLOT_W-1:0];
                fresh_nxt = fresh_r + LEN_W'(1);
              end
              req.val_we    = 1'b1;
              req.val_waddr = (free_cnt_r != '0) ? free_head_r : fresh_r[SLOT_W-1:0];
              req.val_wdata = val_r;
            end
          endcase
        end
      end
      S_ALLOC: begin
        free_head_nxt = link_rdata;
        free_cnt_nxt  = free_cnt_r - LEN_W'(1);
      end
      S_PLACE: begin
        cur_nxt = head_r;
        rem_nxt = SLOT_W'(pos_r - POS_W'(1));
        if (pos_r == '0) begin
          req.link_we    = 1'b1;
          req.link_waddr = new_r;
          req.link_wdata = head_r;
          head_nxt       = new_r;
          len_nxt        = len_r + LEN_W'(1);
          if (pos_r == len_ext) tail_nxt = new_r;
        end
      end
      S_WALK: begin
        cur_nxt = eff_slot;
        if (rem_r != '0) begin
          req.link_re    = 1'b1;
          req.link_raddr = eff_slot;
          rem_nxt        = rem_r - SLOT_W'(1);
          pend_nxt       = 1'b1;
        end else if (op_r == OP_READ) begin
          req.val_re    = 1'b1;
          req.val_raddr = eff_slot;
        end else begin
          // Fetch the successor of the entry before the position.
          req.link_re    = 1'b1;
          req.link_raddr = eff_slot;
        end
      end
      S_VAL: begin
        rv_nxt = val_rdata;
      end
      S_INS_A: begin
        req.link_we    = 1'b1;
        req.link_waddr = new_r;
        req.link_wdata = link_rdata;
      end
      S_INS_B: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur_r;
        req.link_wdata = new_r;
        len_nxt        = len_r + LEN_W'(1);
        if (pos_r == len_ext) tail_nxt = new_r;
      end
      S_DEL_HEAD: begin
        head_nxt = link_rdata;
      end
      S_DEL_V: begin
        victim_nxt     = link_rdata;
        req.link_re    = 1'b1;
        req.link_raddr = link_rdata;
      end
      S_DEL_N: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur_r;
        req.link_wdata = link_rdata;
        if (pos_r == POS_W'(len_r - LEN_W'(1))) tail_nxt = cur_r;
      end
      S_DEL_F: begin
        req.link_we    = 1'b1;
        req.link_waddr = victim_r;
        req.link_wdata = free_head_r;
        free_head_nxt  = victim_r;
        free_cnt_nxt   = free_cnt_r + LEN_W'(1);
        len_nxt        = len_r - LEN_W'(1);
        if (len_r == LEN_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      free_head_r <= '0;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      val_r <= in_value;
    end
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    rem_r    <= rem_nxt;
    new_r    <= new_nxt;
    victim_r <= victim_nxt;
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
    if (state_r == S_RESP && out_free) begin
      out_status_r <= status_r;
      out_rv_r     <= rv_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rv_r;

endmodule

`default_nettype wire
